>>> rtl/core/note_to_frequency_and_duration_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef NOTE_TO_FREQUENCY_AND_DURATION_ASSERT_SVH
`define NOTE_TO_FREQUENCY_AND_DURATION_ASSERT_SVH

// Check that the antecedent implies the consequent on the same edge.
`define NFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("note_to_frequency_and_duration check failed");

// Check a property body as given (may carry a delay).
`define NFD_ASSERT_PROP(lbl, body) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) body) \
    else $error("note_to_frequency_and_duration check failed");

`endif

>>> rtl/core/nfd_pkg.sv
// ----------------------------------------------------------------------------
// nfd_pkg
// Shared types, constants and tables of the note to frequency block.
// ----------------------------------------------------------------------------
package nfd_pkg;

  // Divider: bits resolved per stage and number of stages
  localparam int DivBits   = 4;
  localparam int DivWidth  = 32;
  localparam int DivStages = DivWidth / DivBits;

  // Input register, decode, multiply, prepare, divider chain, output register
  localparam int Latency = 4 + DivStages + 1;

  localparam logic [27:0] DurMax  = 28'hFFF_FFFF;
  localparam logic [15:0] FreqMax = 16'hFFFF;
  localparam logic [2:0]  LetterRest = 3'd7;

  typedef enum logic [2:0] {
    CfgA4Hz       = 3'd0,
    CfgBeatsPerBar = 3'd1,
    CfgBeatUnit   = 3'd2,
    CfgTempoBpm   = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0] a4_hz;
    logic [4:0] beats_per_bar;
    logic [4:0] beat_unit;
    logic [8:0] tempo_bpm;
  } cfg_t;

  // One word in flight through the divider chain
  typedef struct packed {
    logic        valid;
    logic        rest;
    logic        zero;
    logic [15:0] freq;
    logic [21:0] dvs;
    logic [21:0] rem;
    logic [31:0] dvd;
    logic [31:0] quo;
  } div_t;

  // Semitone offset of each letter from A
  function automatic logic signed [4:0] letter_offset(input logic [2:0] letter);
    logic signed [4:0] off;
    case (letter)
      3'd0:    off = -5'sd9;
      3'd1:    off = -5'sd7;
      3'd2:    off = -5'sd5;
      3'd3:    off = -5'sd4;
      3'd4:    off = -5'sd2;
      3'd5:    off = 5'sd0;
      3'd6:    off = 5'sd2;
      default: off = 5'sd0;
    endcase
    return off;
  endfunction

  // round(2^(k/12) * 2^24)
  function automatic logic [24:0] semitone_q24(input logic [3:0] k);
    logic [24:0] v;
    case (k)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd17774841;
      4'd2:    v = 25'd18831788;
      4'd3:    v = 25'd19951585;
      4'd4:    v = 25'd21137968;
      4'd5:    v = 25'd22394897;
      4'd6:    v = 25'd23726566;
      4'd7:    v = 25'd25137421;
      4'd8:    v = 25'd26632170;
      4'd9:    v = 25'd28215802;
      4'd10:   v = 25'd29893600;
      4'd11:   v = 25'd31671166;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  // One restoring division step
  function automatic div_t div_step(input div_t s);
    div_t        o;
    logic [22:0] r;
    logic        qb;
    o  = s;
    r  = {s.rem, s.dvd[31]};
    qb = 1'b0;
    if (r >= {1'b0, s.dvs}) begin
      r  = r - {1'b0, s.dvs};
      qb = 1'b1;
    end
    o.rem = r[21:0];
    o.dvd = {s.dvd[30:0], 1'b0};
    o.quo = {s.quo[30:0], qb};
    return o;
  endfunction

endpackage

>>> rtl/core/nfd_front.sv
// ----------------------------------------------------------------------------
// nfd_front
// Four register stages: capture, decode and small products, wide products,
// then rounding of the frequency and setup of the duration division.
// ----------------------------------------------------------------------------
module nfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nfd_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  input  logic [2:0]    note_letter_i,
  input  logic [2:0]    accidental_i,
  input  logic [3:0]    octave_i,
  input  logic [6:0]    length_num_i,
  input  logic [6:0]    length_den_i,
  output nfd_pkg::div_t div_o
);

  // Stage A: capture the word
  logic       a_valid_q;
  logic [2:0] a_letter_q;
  logic [2:0] a_acc_q;
  logic [3:0] a_oct_q;
  logic [6:0] a_num_q;
  logic [6:0] a_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_letter_q <= note_letter_i;
    a_acc_q    <= accidental_i;
    a_oct_q    <= octave_i;
    a_num_q    <= length_num_i;
    a_den_q    <= length_den_i;
  end

  // Decode semitone distance, biased by six octaves, into octave and step
  logic signed [9:0] biased_s;
  logic [7:0]  biased;
  logic [15:0] recip;
  logic [4:0]  oct_q5;
  logic [7:0]  k_w;
  logic [7:0]  oct12;

  always_comb begin
    oct12    = 8'({4'd0, a_oct_q} * 8'd12);
    biased_s = 10'sd24 + 10'(nfd_pkg::letter_offset(a_letter_q))
             + $signed({2'b00, oct12}) + 10'($signed(a_acc_q));
    biased   = biased_s[7:0];
    recip    = 16'({8'd0, biased} * 16'd171);
    oct_q5   = recip[15:11];
    k_w      = 8'(biased - 8'({3'd0, oct_q5} * 8'd12));
  end

  // Stage B: step index, shift, partial products
  logic        b_valid_q;
  logic        b_rest_q;
  logic [3:0]  b_k_q;
  logic [4:0]  b_shift_q;
  logic [11:0] b_num_bpb_q;
  logic [13:0] b_tempo_unit_q;
  logic [6:0]  b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rest_q       <= (a_letter_q == nfd_pkg::LetterRest);
    b_k_q          <= k_w[3:0];
    b_shift_q      <= 5'(5'd30 - oct_q5);
    b_num_bpb_q    <= 12'({7'd0, cfg_i.beats_per_bar} * {5'd0, a_num_q});
    b_tempo_unit_q <= 14'({5'd0, cfg_i.tempo_bpm} * {9'd0, cfg_i.beat_unit});
    b_den_q        <= a_den_q;
  end

  // Stage C: pitch product and the two duration terms
  logic        c_valid_q;
  logic        c_rest_q;
  logic [4:0]  c_shift_q;
  logic [34:0] c_prod_q;
  logic [29:0] c_top_q;
  logic [20:0] c_bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_rest_q   <= b_rest_q;
    c_shift_q  <= b_shift_q;
    c_prod_q   <= 35'({25'd0, cfg_i.a4_hz} * {10'd0, nfd_pkg::semitone_q24(b_k_q)});
    c_top_q    <= 30'({18'd0, b_num_bpb_q} * 30'd240000);
    c_bottom_q <= 21'({7'd0, b_tempo_unit_q} * {14'd0, b_den_q});
  end

  // Round the frequency half up, saturate; set up the division
  logic [35:0]   half;
  logic [35:0]   shifted;
  logic [15:0]   freq;
  nfd_pkg::div_t div_d;

  always_comb begin
    half    = 36'd1 << (c_shift_q - 5'd1);
    shifted = ({1'b0, c_prod_q} + half) >> c_shift_q;
    if (c_rest_q) begin
      freq = 16'd0;
    end else if (shifted > 36'(nfd_pkg::FreqMax)) begin
      freq = nfd_pkg::FreqMax;
    end else begin
      freq = shifted[15:0];
    end
    div_d.valid = c_valid_q;
    div_d.rest  = c_rest_q;
    div_d.zero  = (c_bottom_q == 21'd0);
    div_d.freq  = freq;
    div_d.dvs   = {c_bottom_q, 1'b0};
    div_d.rem   = 22'd0;
    div_d.dvd   = 32'({c_top_q, 1'b0}) + 32'(c_bottom_q);
    div_d.quo   = 32'd0;
  end

  // Stage D register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_o <= '0;
    end else begin
      div_o <= div_d;
    end
  end

endmodule

>>> rtl/core/nfd_div_stage.sv
// ----------------------------------------------------------------------------
// nfd_div_stage
// One stage of the pipelined restoring divider: resolves DivBits (4) quotient bits.
// ----------------------------------------------------------------------------
module nfd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nfd_pkg::div_t div_i,
  output nfd_pkg::div_t div_o
);

  nfd_pkg::div_t div_d;

  // Run the steps of this stage back to back
  always_comb begin
    div_d = div_i;
    for (int i = 0; i < nfd_pkg::DivBits; i++) begin
      div_d = nfd_pkg::div_step(div_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_o <= '0;
    end else begin
      div_o <= div_d;
    end
  end

endmodule

>>> rtl/core/note_to_frequency_and_duration.sv
// Pipeline: 4 front stages, 8 divider stages and one output register from start
// to done_o. Throughput: one word per cycle, set by the divider chain, which
// resolves 4 quotient bits per stage. busy stays low. Reset: asynchronous,
// active low; clears all valid bits and loads the configuration registers
// with A4 = 440 Hz, 4/4 time, 120 bpm. The receiver cannot stall.
// ----------------------------------------------------------------------------
// note_to_frequency_and_duration
// Gives the pitch and the length in milliseconds of one decoded note.
// ----------------------------------------------------------------------------
module note_to_frequency_and_duration (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  note_letter_i,
  input  logic [2:0]  accidental_i,
  input  logic [3:0]  octave_i,
  input  logic [6:0]  length_num_i,
  input  logic [6:0]  length_den_i,
  output logic        done_o,
  output logic [15:0] frequency_hz_o,
  output logic [27:0] duration_ms_o,
  output logic        is_rest_o
);

  // Configuration registers
  nfd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a4_hz         <= 10'd440;
      cfg_q.beats_per_bar <= 5'd4;
      cfg_q.beat_unit     <= 5'd4;
      cfg_q.tempo_bpm     <= 9'd120;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nfd_pkg::CfgA4Hz:        cfg_q.a4_hz         <= cfg_data_i;
        nfd_pkg::CfgBeatsPerBar: cfg_q.beats_per_bar <= cfg_data_i[4:0];
        nfd_pkg::CfgBeatUnit:    cfg_q.beat_unit     <= cfg_data_i[4:0];
        nfd_pkg::CfgTempoBpm:    cfg_q.tempo_bpm     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Fully pipelined: a word is taken every cycle
  assign busy = 1'b0;

  nfd_pkg::div_t div_s [0:nfd_pkg::DivStages];

  nfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (start && !busy),
    .note_letter_i (note_letter_i),
    .accidental_i  (accidental_i),
    .octave_i      (octave_i),
    .length_num_i  (length_num_i),
    .length_den_i  (length_den_i),
    .div_o         (div_s[0])
  );

  // Divider chain
  for (genvar g = 0; g < nfd_pkg::DivStages; g++) begin : g_div
    nfd_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .div_i  (div_s[g]),
      .div_o  (div_s[g+1])
    );
  end

  // Saturate the quotient and register the result word
  logic        done_q;
  logic [15:0] freq_q;
  logic [27:0] dur_q;
  logic        rest_q;
  logic [27:0] dur_d;

  always_comb begin
    if (div_s[nfd_pkg::DivStages].zero ||
        div_s[nfd_pkg::DivStages].quo > 32'(nfd_pkg::DurMax)) begin
      dur_d = nfd_pkg::DurMax;
    end else begin
      dur_d = div_s[nfd_pkg::DivStages].quo[27:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_s[nfd_pkg::DivStages].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= div_s[nfd_pkg::DivStages].freq;
    dur_q  <= dur_d;
    rest_q <= div_s[nfd_pkg::DivStages].rest;
  end

  assign done_o         = done_q;
  assign frequency_hz_o = freq_q;
  assign duration_ms_o  = dur_q;
  assign is_rest_o      = rest_q;

endmodule

>>> rtl/core/nfd_checker.sv
// ----------------------------------------------------------------------------
// nfd_checker
// Port-level checks of result timing and rest handling.
// ----------------------------------------------------------------------------
`include "note_to_frequency_and_duration_assert.svh"

module nfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  note_letter_i,
  input logic        done_o,
  input logic        is_rest_o,
  input logic [15:0] frequency_hz_o
);

  // Every accepted word yields one result on done_o
  `NFD_ASSERT_PROP(a_result_follows, (start && !busy) |-> ##13 done_o)
  // No result without a word taken earlier
  `NFD_ASSERT_IMPL(a_no_spurious, done_o, $past(start && !busy, 13))
  // Rest flag matches the letter taken
  `NFD_ASSERT_IMPL(a_rest_flag, done_o, is_rest_o == ($past(note_letter_i, 13) == nfd_pkg::LetterRest))
  // A rest has no pitch
  `NFD_ASSERT_IMPL(a_rest_silent, done_o && is_rest_o, frequency_hz_o == 16'd0)

endmodule

bind note_to_frequency_and_duration nfd_checker u_nfd_checker (.*);
